>>> src/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

   // Frame limits and field widths.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 3 * CHAN_W;

   // Line store: three row slots of MAX_WIDTH pixels, addressed as {slot, column}.
   localparam int SLOT_W     = 2;
   localparam int LINE_DEPTH = 3 * MAX_WIDTH;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);

   // Window sums and the rounding divider.
   localparam int SUM_W   = 12;
   localparam int COUNT_W = 4;
   localparam int NUMER_W = SUM_W + 1;
   localparam int DENOM_W = COUNT_W + 1;
   localparam int STEP_W  = $clog2(CHAN_W);

   // Register indexes of the configuration port.
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Operation codes of an input transfer.
   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef logic [COL_W-1:0]      col_type;
   typedef logic [ROW_W-1:0]      row_type;
   typedef logic [WIDTH_W-1:0]    width_type;
   typedef logic [HEIGHT_W-1:0]   height_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CHAN_W-1:0]     chan_type;
   typedef logic [PIXEL_W-1:0]    pixel_type;
   typedef logic [SUM_W-1:0]      sum_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [NUMER_W-1:0]    numer_type;
   typedef logic [DENOM_W-1:0]    denom_type;
   typedef logic [STEP_W-1:0]     step_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      mem_we;
      addr_type  mem_waddr;
      logic      mem_re;
      addr_type  mem_raddr;
      logic      acc_clr;
      logic      div_start;
      count_type div_count;
      logic      out_load;
      logic      out_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> src/bb3_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in one channel, so the divisor starts shifted up by CHAN_W-1 places.
module bb3_div (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  bb3_pkg::numer_type  numer,
   input  bb3_pkg::denom_type  denom,
   output bb3_pkg::chan_type   quot,
   output logic                done
);

   logic                                            busy_ff, busy_in;
   logic                                            done_ff, done_in;
   bb3_pkg::step_type                               step_ff, step_in;
   bb3_pkg::numer_type                              rem_ff, rem_in;
   logic [bb3_pkg::DENOM_W+bb3_pkg::CHAN_W-2:0]     dsh_ff, dsh_in;
   bb3_pkg::chan_type                               quot_ff, quot_in;
   logic                                            fits;

   // One compare and subtract step.
   always_comb begin
      fits    = rem_ff >= bb3_pkg::numer_type'(dsh_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = bb3_pkg::step_type'(bb3_pkg::CHAN_W - 1);
         rem_in  = numer;
         dsh_in  = {denom, {(bb3_pkg::CHAN_W-1){1'b0}}};
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - bb3_pkg::numer_type'(dsh_ff);
         end
         dsh_in  = dsh_ff >> 1;
         quot_in = {quot_ff[bb3_pkg::CHAN_W-2:0], fits};
         step_in = step_ff - bb3_pkg::step_type'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Operand registers.
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> src/bb3_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Datapath: line store, window accumulators, dividers and the result register.
module bb3_dp (
   input  wire                  clock,
   input  wire                  reset,
   input  bb3_pkg::cmd_type     cmd,
   output bb3_pkg::status_type  status,
   input  wire  [7:0]           req_in_red,
   input  wire  [7:0]           req_in_green,
   input  wire  [7:0]           req_in_blue,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [7:0]           rsp_out_red,
   output logic [7:0]           rsp_out_green,
   output logic [7:0]           rsp_out_blue,
   output logic                 rsp_frame_last
);

   bb3_pkg::pixel_type  line_mem [bb3_pkg::LINE_DEPTH];
   bb3_pkg::pixel_type  rdata_ff;
   logic                acc_en_ff;
   bb3_pkg::sum_type    acc_ff [3];
   bb3_pkg::sum_type    acc_in [3];
   bb3_pkg::chan_type   quot [3];
   logic [2:0]          done;
   bb3_pkg::numer_type  numer [3];
   bb3_pkg::denom_type  denom;
   logic                valid_ff, valid_in;
   bb3_pkg::chan_type   red_ff, green_ff, blue_ff;
   logic                last_ff;

   // Line store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         line_mem[cmd.mem_waddr] <= {req_in_red, req_in_green, req_in_blue};
      end
      if (cmd.mem_re) begin
         rdata_ff <= line_mem[cmd.mem_raddr];
      end
   end

   // Accumulate each read word in the cycle after it lands.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = acc_ff[k];
         if (cmd.acc_clr) begin
            acc_in[k] = '0;
         end else if (acc_en_ff) begin
            acc_in[k] = acc_ff[k] + bb3_pkg::sum_type'(
               rdata_ff[(2-k)*bb3_pkg::CHAN_W +: bb3_pkg::CHAN_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.mem_re;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         acc_ff[k] <= acc_in[k];
      end
   end

   // Rounded mean: (2*sum + count) / (2*count), one divider per channel.
   assign denom = {cmd.div_count, 1'b0};

   for (genvar g = 0; g < 3; g++) begin : g_chan
      assign numer[g] = {acc_ff[g], 1'b0} + bb3_pkg::numer_type'(cmd.div_count);

      bb3_div u_div (
         .clock (clock),
         .reset (reset),
         .start (cmd.div_start),
         .numer (numer[g]),
         .denom (denom),
         .quot  (quot[g]),
         .done  (done[g])
      );
   end

   // Result register; it frees up in the cycle its transfer completes.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         red_ff   <= quot[0];
         green_ff <= quot[1];
         blue_ff  <= quot[2];
         last_ff  <= cmd.out_last;
      end
   end

   assign status.div_done = &done;
   assign status.out_free = !valid_ff || !rsp_stall;

   assign rsp_valid      = valid_ff;
   assign rsp_out_red    = red_ff;
   assign rsp_out_green  = green_ff;
   assign rsp_out_blue   = blue_ff;
   assign rsp_frame_last = last_ff;

endmodule

`default_nettype wire

>>> src/bb3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Controller: frame position, configuration, and the window scan sequence.
module bb3_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_op,
   output logic                 req_stall,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire                  csr_index,
   input  wire  [12:0]          csr_wdata,
   output bb3_pkg::cmd_type     cmd,
   input  bb3_pkg::status_type  status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_DIV,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   state_type              state_ff, state_in;
   bb3_pkg::width_type     fw_ff, fw_in;
   bb3_pkg::height_type    fh_ff, fh_in;
   bb3_pkg::row_type       row_ff, row_in;
   bb3_pkg::col_type       col_ff, col_in;
   bb3_pkg::slot_type      slot_ff, slot_in;
   bb3_pkg::col_type       drain_ff, drain_in;
   bb3_pkg::slot_type      t_slot_ff, t_slot_in;
   bb3_pkg::col_type       t_col_ff, t_col_in;
   logic                   has_top_ff, has_top_in;
   logic                   has_bot_ff, has_bot_in;
   logic                   second_ff, second_in;
   logic                   last_ff, last_in;
   bb3_pkg::slot_type      cur_slot_ff, cur_slot_in;
   bb3_pkg::col_type       cur_col_ff, cur_col_in;
   logic [1:0]             row_idx_ff, row_idx_in;

   function automatic bb3_pkg::slot_type slot_inc(bb3_pkg::slot_type s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic bb3_pkg::slot_type slot_dec(bb3_pkg::slot_type s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

   always_comb begin
      bb3_pkg::width_type  w;
      bb3_pkg::height_type h;
      logic                left, right, emit_a, emit_b, start_scan;
      bb3_pkg::col_type    c0, c1;
      bb3_pkg::count_type  nrows, ncols;

      // Effective frame size: zero acts as one, large values saturate.
      if (fw_ff == '0) begin
         w = bb3_pkg::width_type'(1);
      end else if (fw_ff > bb3_pkg::width_type'(bb3_pkg::MAX_WIDTH)) begin
         w = bb3_pkg::width_type'(bb3_pkg::MAX_WIDTH);
      end else begin
         w = fw_ff;
      end
      if (fh_ff == '0) begin
         h = bb3_pkg::height_type'(1);
      end else if (fh_ff > bb3_pkg::height_type'(bb3_pkg::MAX_HEIGHT)) begin
         h = bb3_pkg::height_type'(bb3_pkg::MAX_HEIGHT);
      end else begin
         h = fh_ff;
      end

      // Window bounds of the current target pixel.
      left  = t_col_ff != '0;
      right = (bb3_pkg::width_type'(t_col_ff) + bb3_pkg::width_type'(1)) < w;
      c0    = left  ? t_col_ff - bb3_pkg::col_type'(1) : t_col_ff;
      c1    = right ? t_col_ff + bb3_pkg::col_type'(1) : t_col_ff;
      nrows = bb3_pkg::count_type'(1) + bb3_pkg::count_type'(has_top_ff)
            + bb3_pkg::count_type'(has_bot_ff);
      ncols = bb3_pkg::count_type'(1) + bb3_pkg::count_type'(left)
            + bb3_pkg::count_type'(right);

      state_in    = state_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      slot_in     = slot_ff;
      drain_in    = drain_ff;
      t_slot_in   = t_slot_ff;
      t_col_in    = t_col_ff;
      has_top_in  = has_top_ff;
      has_bot_in  = has_bot_ff;
      second_in   = second_ff;
      last_in     = last_ff;
      cur_slot_in = cur_slot_ff;
      cur_col_in  = cur_col_ff;
      row_idx_in  = row_idx_ff;
      emit_a      = 1'b0;
      emit_b      = 1'b0;
      start_scan  = 1'b0;
      cmd         = '0;

      unique case (state_ff)
         // Take one item: store a pixel or start a drained result.
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == bb3_pkg::OP_PIXEL) begin
                  if (row_ff < h && bb3_pkg::width_type'(col_ff) < w) begin
                     cmd.mem_we    = 1'b1;
                     cmd.mem_waddr = {slot_ff, col_ff};
                     emit_a = (row_ff != '0) && (col_ff != '0);
                     emit_b = (row_ff != '0)
                            && (bb3_pkg::width_type'(col_ff) == w - bb3_pkg::width_type'(1));
                     t_slot_in  = slot_inc(slot_inc(slot_ff));
                     t_col_in   = emit_a ? col_ff - bb3_pkg::col_type'(1) : col_ff;
                     has_top_in = row_ff > bb3_pkg::row_type'(1);
                     has_bot_in = 1'b1;
                     second_in  = emit_a && emit_b;
                     last_in    = 1'b0;
                     start_scan = emit_a || emit_b;
                     if ((bb3_pkg::width_type'(col_ff) + bb3_pkg::width_type'(1)) >= w) begin
                        col_in  = '0;
                        row_in  = row_ff + bb3_pkg::row_type'(1);
                        slot_in = slot_inc(slot_ff);
                     end else begin
                        col_in = col_ff + bb3_pkg::col_type'(1);
                     end
                  end
               end else if (row_ff >= h && bb3_pkg::width_type'(drain_ff) < w) begin
                  t_slot_in  = slot_inc(slot_inc(slot_ff));
                  t_col_in   = drain_ff;
                  has_top_in = h > bb3_pkg::height_type'(1);
                  has_bot_in = 1'b0;
                  second_in  = 1'b0;
                  last_in    = bb3_pkg::width_type'(drain_ff) == w - bb3_pkg::width_type'(1);
                  start_scan = 1'b1;
                  if (last_in) begin
                     row_in   = '0;
                     col_in   = '0;
                     drain_in = '0;
                     slot_in  = '0;
                  end else begin
                     drain_in = drain_ff + bb3_pkg::col_type'(1);
                  end
               end
            end
         end

         // Read the window one pixel per cycle, row by row.
         ST_SCAN: begin
            cmd.mem_re    = 1'b1;
            cmd.mem_raddr = {cur_slot_ff, cur_col_ff};
            if (cur_col_ff == c1) begin
               cur_col_in = c0;
               if (bb3_pkg::count_type'(row_idx_ff) == nrows - bb3_pkg::count_type'(1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  row_idx_in  = row_idx_ff + 2'd1;
                  cur_slot_in = slot_inc(cur_slot_ff);
               end
            end else begin
               cur_col_in = cur_col_ff + bb3_pkg::col_type'(1);
            end
         end

         // Let the last read word reach the accumulators.
         ST_FLUSH: begin
            state_in = ST_DIV;
         end

         ST_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_count = bb3_pkg::count_type'(nrows * ncols);
            state_in      = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end

         // Hand the result to the output register, then the second one if any.
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = last_ff;
               if (second_ff) begin
                  second_in  = 1'b0;
                  t_col_in   = t_col_ff + bb3_pkg::col_type'(1);
                  start_scan = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Set up the scan of a new target pixel.
      if (start_scan) begin
         state_in    = ST_SCAN;
         cmd.acc_clr = 1'b1;
         row_idx_in  = 2'd0;
         cur_slot_in = has_top_in ? slot_dec(t_slot_in) : t_slot_in;
         cur_col_in  = (t_col_in != '0) ? t_col_in - bb3_pkg::col_type'(1) : t_col_in;
      end

      // A register write restarts the frame.
      if (csr_valid) begin
         unique case (csr_index)
            bb3_pkg::CSR_FRAME_WIDTH:  fw_in = csr_wdata[bb3_pkg::WIDTH_W-1:0];
            bb3_pkg::CSR_FRAME_HEIGHT: fh_in = csr_wdata[bb3_pkg::HEIGHT_W-1:0];
            default:                   fw_in = fw_ff;
         endcase
         row_in   = '0;
         col_in   = '0;
         drain_in = '0;
         slot_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fw_ff       <= bb3_pkg::width_type'(640);
         fh_ff       <= bb3_pkg::height_type'(480);
         row_ff      <= '0;
         col_ff      <= '0;
         slot_ff     <= '0;
         drain_ff    <= '0;
         t_slot_ff   <= '0;
         t_col_ff    <= '0;
         has_top_ff  <= 1'b0;
         has_bot_ff  <= 1'b0;
         second_ff   <= 1'b0;
         last_ff     <= 1'b0;
         cur_slot_ff <= '0;
         cur_col_ff  <= '0;
         row_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         slot_ff     <= slot_in;
         drain_ff    <= drain_in;
         t_slot_ff   <= t_slot_in;
         t_col_ff    <= t_col_in;
         has_top_ff  <= has_top_in;
         has_bot_ff  <= has_bot_in;
         second_ff   <= second_in;
         last_ff     <= last_in;
         cur_slot_ff <= cur_slot_in;
         cur_col_ff  <= cur_col_in;
         row_idx_ff  <= row_idx_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

>>> src/box_blur_3x3_edge_normalized.sv
// 3x3 box blur of an RGB frame, normalized at the frame edges.
// Input channel (req_): one transfer per pixel in raster order (req_op = 0),
// or a drain tick (req_op = 1) once the frame is in. A result (rsp_) is the
// rounded mean of the in-frame 3x3 neighbors, one row and one pixel behind.
// Past the first row, a pixel in the last column causes two results (one if
// the frame is one pixel wide); each drain tick causes one pixel of the last
// row, and rsp_frame_last marks the final one of a frame. Configuration
// (csr_): index 0 is frame_width, index 1 is frame_height; a write restarts
// the frame. csr_ready is always high. Each result reads its window of 1 to 9
// pixels through the single read port of the line store, one window pixel
// per cycle, and the dividers produce one quotient bit per cycle.
// req_stall is high while an item is in work. The result register lets the
// next item start while a result waits; a stalled result holds its value and
// the block waits before it loads the next one.
// Reset sets a 640x480 frame at its first pixel. The line store needs no
// clearing: only entries written earlier in the frame are read.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_edge_normalized (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire         req_op,
   input  wire  [7:0]  req_in_red,
   input  wire  [7:0]  req_in_green,
   input  wire  [7:0]  req_in_blue,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_frame_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [12:0] csr_wdata
);

   bb3_pkg::cmd_type    cmd;
   bb3_pkg::status_type status;

   // Sequencer and frame position.
   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   // Line store, sums, dividers and result register.
   bb3_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // One blurred output pixel as the block should deliver it.
   typedef struct packed {
      bb3_pkg::chan_type red;
      bb3_pkg::chan_type green;
      bb3_pkg::chan_type blue;
      logic              last;
   } blurred_pixel_type;

   localparam int unsigned SETTLE_CYCLES  = 32;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS    = 10;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [7:0]  req_in_red;
   logic [7:0]  req_in_green;
   logic [7:0]  req_in_blue;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        rsp_frame_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [12:0] csr_wdata;

   // Predictor state: three row slots, frame position and the two registers.
   bb3_pkg::pixel_type frame_rows [3][bb3_pkg::MAX_WIDTH];
   int unsigned        in_row;
   int unsigned        in_col;
   int unsigned        drain_pos;
   int unsigned        cfg_width;
   int unsigned        cfg_height;
   blurred_pixel_type  pending_blur [$];

   // Idle rates in percent, and run statistics.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned items_sent;
   int unsigned items_effective;
   int unsigned results_checked;
   int unsigned frames_done;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   box_blur_3x3_edge_normalized u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // A register value of zero means one; larger values saturate at the limit.
   function automatic int unsigned clamp_dim(int unsigned value, int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // Rounded mean of the in-frame 3x3 neighbors of pixel (r, c).
   function automatic blurred_pixel_type window_mean(int unsigned r, int unsigned c,
                                                     int unsigned w, int unsigned h,
                                                     logic last);
      blurred_pixel_type  res;
      bb3_pkg::pixel_type px;
      int unsigned        sum_r, sum_g, sum_b, count, r0, c0, rr, cc;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      count = 0;
      r0 = (r > 0) ? r - 1 : 0;
      c0 = (c > 0) ? c - 1 : 0;
      for (rr = r0; rr <= r + 1 && rr < h; rr++) begin
         for (cc = c0; cc <= c + 1 && cc < w; cc++) begin
            px = frame_rows[rr % 3][cc];
            sum_r += px[23:16];
            sum_g += px[15:8];
            sum_b += px[7:0];
            count++;
         end
      end
      // Round half up.
      res.red   = bb3_pkg::chan_type'((2 * sum_r + count) / (2 * count));
      res.green = bb3_pkg::chan_type'((2 * sum_g + count) / (2 * count));
      res.blue  = bb3_pkg::chan_type'((2 * sum_b + count) / (2 * count));
      res.last  = last;
      return res;
   endfunction

   // Advances the predictor by one accepted transfer and queues the blurred
   // pixels it releases. Returns 0 when the block ignores the transfer.
   function automatic bit blur_predict(bb3_pkg::op_type op, bb3_pkg::chan_type red,
                                       bb3_pkg::chan_type green, bb3_pkg::chan_type blue);
      int unsigned w, h, r, c;
      w = clamp_dim(cfg_width, bb3_pkg::MAX_WIDTH);
      h = clamp_dim(cfg_height, bb3_pkg::MAX_HEIGHT);
      if (op == bb3_pkg::OP_PIXEL) begin
         r = in_row;
         c = in_col;
         // Pixels after the last row wait for the drain and are dropped.
         if (r >= h || c >= w) return 0;
         frame_rows[r % 3][c] = {red, green, blue};
         if (r >= 1) begin
            if (c >= 1) pending_blur.push_back(window_mean(r - 1, c - 1, w, h, 1'b0));
            if (c == w - 1) pending_blur.push_back(window_mean(r - 1, c, w, h, 1'b0));
         end
         if (c + 1 >= w) begin
            in_col = 0;
            in_row = r + 1;
         end else begin
            in_col = c + 1;
         end
         return 1;
      end
      // A drain tick before the frame is complete does nothing.
      if (in_row < h || drain_pos >= w) return 0;
      pending_blur.push_back(window_mean(h - 1, drain_pos, w, h, drain_pos == w - 1));
      if (drain_pos == w - 1) begin
         in_row = 0;
         in_col = 0;
         drain_pos = 0;
      end else begin
         drain_pos++;
      end
      return 1;
   endfunction

   function automatic bb3_pkg::chan_type rand_chan();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return bb3_pkg::chan_type'($urandom_range(255));
      endcase
   endfunction

   task automatic note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // Sends one item, with random idle cycles first, and returns once it is taken.
   task automatic send_item(bb3_pkg::op_type op, bb3_pkg::chan_type red,
                            bb3_pkg::chan_type green, bb3_pkg::chan_type blue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_in_red   <= red;
      req_in_green <= green;
      req_in_blue  <= blue;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (blur_predict(op, red, green, blue)) items_effective++;
   endtask

   // Holds the input idle until every expected result is in, then lets the
   // block finish any item that releases no result.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_blur.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the block idle; each restarts the frame.
   task automatic write_register(logic index, int unsigned value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[12:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == bb3_pkg::CSR_FRAME_WIDTH) cfg_width = value & 'h7FF;
      else cfg_height = value & 'h1FFF;
      in_row = 0;
      in_col = 0;
      drain_pos = 0;
   endtask

   // Sends n pixels; some are preceded by an early drain tick, which is ignored.
   task automatic send_pixels(int unsigned n, int unsigned noise_pct);
      int unsigned i;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_item(bb3_pkg::OP_DRAIN, rand_chan(), rand_chan(), rand_chan());
         if ($urandom_range(199) == 0) wait_drained();
         send_item(bb3_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      end
   endtask

   task automatic send_drains(int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++)
         send_item(bb3_pkg::OP_DRAIN, rand_chan(), rand_chan(), rand_chan());
   endtask

   // A whole frame at the current size, then its drain, each maybe followed by a stray item.
   task automatic send_frame(int unsigned noise_pct);
      int unsigned w, h;
      w = clamp_dim(cfg_width, bb3_pkg::MAX_WIDTH);
      h = clamp_dim(cfg_height, bb3_pkg::MAX_HEIGHT);
      send_pixels(w * h, noise_pct);
      if ($urandom_range(99) < noise_pct)
         send_item(bb3_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      send_drains(w);
      if ($urandom_range(99) < noise_pct) send_drains(1);
   endtask

   // Right after reset the frame is 640x480: the first row releases nothing,
   // and a drain tick this early is ignored.
   task automatic test_reset_geometry();
      send_item(bb3_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
      send_item(bb3_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_item(bb3_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h00);
      send_item(bb3_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      send_item(bb3_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h00);
      send_item(bb3_pkg::OP_PIXEL, 8'h00, 8'h00, 8'hFF);
      send_item(bb3_pkg::OP_PIXEL, 8'h80, 8'h7F, 8'h01);
   endtask

   // Zero in both registers gives a one-pixel frame: a pixel past the end and
   // a drain tick after the frame is done are both ignored.
   task automatic test_single_pixel();
      write_register(bb3_pkg::CSR_FRAME_WIDTH, 0);
      write_register(bb3_pkg::CSR_FRAME_HEIGHT, 0);
      send_item(bb3_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'hAA);
      send_item(bb3_pkg::OP_PIXEL, 8'h12, 8'h34, 8'h56);
      send_item(bb3_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
      send_item(bb3_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
      send_item(bb3_pkg::OP_PIXEL, 8'h00, 8'hFF, 8'h55);
      send_item(bb3_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
   endtask

   // A 3x3 frame holds corner, edge and interior windows.
   task automatic test_three_by_three();
      int unsigned k;
      write_register(bb3_pkg::CSR_FRAME_WIDTH, 3);
      write_register(bb3_pkg::CSR_FRAME_HEIGHT, 3);
      for (k = 0; k < 9; k++) begin
         if (k == 8) send_item(bb3_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
         send_item(bb3_pkg::OP_PIXEL, bb3_pkg::chan_type'(k * 31),
                   bb3_pkg::chan_type'(255 - k * 29), (k % 2) ? 8'hFF : 8'h00);
      end
      send_item(bb3_pkg::OP_PIXEL, 8'h55, 8'hAA, 8'h55);
      send_drains(3);
   endtask

   // An oversized width register saturates at its maximum, which the first
   // results of the second row show.
   task automatic test_saturated_sizes();
      write_register(bb3_pkg::CSR_FRAME_WIDTH, 'h7FF);
      write_register(bb3_pkg::CSR_FRAME_HEIGHT, 3);
      send_pixels(bb3_pkg::MAX_WIDTH + 6, 0);
   endtask

   // Mostly whole frames of random small sizes with random content; some are
   // cut short by a register write, and a few stray drain ticks and pixels.
   task automatic test_random_frames(int unsigned target);
      int unsigned start, w, h, value;
      bit          must_write;
      start = items_effective;
      must_write = 1'b1;
      while (items_effective - start < target) begin
         if (must_write || $urandom_range(3) != 0) begin
            value = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 10);
            if ($urandom_range(9) == 0) value |= $urandom_range(3) << 11;
            write_register(bb3_pkg::CSR_FRAME_WIDTH, value);
         end
         if (must_write || $urandom_range(3) != 0) begin
            value = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
            write_register(bb3_pkg::CSR_FRAME_HEIGHT, value);
         end
         w = clamp_dim(cfg_width, bb3_pkg::MAX_WIDTH);
         h = clamp_dim(cfg_height, bb3_pkg::MAX_HEIGHT);
         if ($urandom_range(99) < 10) begin
            send_pixels($urandom_range(w * h - 1), 5);
            must_write = 1'b1;
         end else begin
            send_frame(5);
            must_write = 1'b0;
         end
      end
   endtask

   // Receiver stall.
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // Compare each delivered result with the oldest expected one.
   always @(posedge clock) begin
      blurred_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (rsp_frame_last) frames_done++;
         if (pending_blur.size() == 0) begin
            note_failure($sformatf("result %0d arrived with none pending: %0d %0d %0d last %0b",
                                   results_checked, rsp_out_red, rsp_out_green,
                                   rsp_out_blue, rsp_frame_last));
         end else begin
            want = pending_blur.pop_front();
            if (rsp_out_red !== want.red)
               note_failure($sformatf("result %0d red: expected %0d, got %0d",
                                      results_checked, want.red, rsp_out_red));
            if (rsp_out_green !== want.green)
               note_failure($sformatf("result %0d green: expected %0d, got %0d",
                                      results_checked, want.green, rsp_out_green));
            if (rsp_out_blue !== want.blue)
               note_failure($sformatf("result %0d blue: expected %0d, got %0d",
                                      results_checked, want.blue, rsp_out_blue));
            if (rsp_frame_last !== want.last)
               note_failure($sformatf("result %0d frame_last: expected %0b, got %0b",
                                      results_checked, want.last, rsp_frame_last));
         end
      end
   end

   // Watchdog: ends the run after too long without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, pending_blur.size());
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = bb3_pkg::OP_PIXEL;
      req_in_red   = 8'h00;
      req_in_green = 8'h00;
      req_in_blue  = 8'h00;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = bb3_pkg::CSR_FRAME_WIDTH;
      csr_wdata    = '0;
      cfg_width    = 640;
      cfg_height   = 480;
      in_row       = 0;
      in_col       = 0;
      drain_pos    = 0;
      items_sent      = 0;
      items_effective = 0;
      results_checked = 0;
      frames_done     = 0;
      mismatch_count  = 0;
      quiet_cycles    = 0;
      send_idle_pct   = 29;
      recv_stall_pct  = 57;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_single_pixel();
      test_three_by_three();
      test_saturated_sizes();
      test_random_frames(125);
      send_idle_pct  = 57;
      recv_stall_pct = 29;
      test_random_frames(125);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_frames(130);
      wait_drained();

      $display("Sent %0d items (%0d taking effect), checked %0d blurred pixels over %0d frames,",
               items_sent, items_effective, results_checked, frames_done);
      $display("with corner, edge and interior windows, saturated sizes and aborted frames.");
      if (mismatch_count == 0 && pending_blur.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_blur.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
